// ----- rtl/sccb_rm_pkg.sv -----
// ----------------------------------------------------------------------------
// SCCB register master package
// Shared types, codes and constants for the SCCB register master.
// ----------------------------------------------------------------------------
package sccb_rm_pkg;

  // Reset values of the configuration registers, and the default read length limit.
  localparam logic [7:0]  DevAddrReset    = 8'd66;
  localparam logic [15:0] DelayTicksReset = 16'd400;
  localparam int unsigned MaxReadBytesDef = 256;

  // Configuration register indexes.
  localparam logic CfgDevAddr    = 1'b0;
  localparam logic CfgDelayTicks = 1'b1;

  // Request codes.
  localparam logic [1:0] ReqNone  = 2'd0;
  localparam logic [1:0] ReqWrite = 2'd1;
  localparam logic [1:0] ReqRead  = 2'd2;

  // Status codes.
  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatBusBusy = 2'd1;
  localparam logic [1:0] StatNoAck   = 2'd2;

  // Last sequence step and the steps that send the stop after a missing acknowledge.
  localparam logic [3:0] SeqLast     = 4'd11;
  localparam logic [3:0] SeqWrStop   = 4'd7;
  localparam logic [3:0] SeqRdStop   = 4'd10;

  // Bus phases, one-hot.
  typedef enum logic [19:0] {
    PH_IDLE = 20'h00001,
    PH_ST_A = 20'h00002,
    PH_ST_B = 20'h00004,
    PH_ST_C = 20'h00008,
    PH_TX_A = 20'h00010,
    PH_TX_B = 20'h00020,
    PH_TX_C = 20'h00040,
    PH_AW_A = 20'h00080,
    PH_AW_B = 20'h00100,
    PH_AW_C = 20'h00200,
    PH_SP_A = 20'h00400,
    PH_SP_B = 20'h00800,
    PH_SP_C = 20'h01000,
    PH_SP_D = 20'h02000,
    PH_RX_A = 20'h04000,
    PH_RX_B = 20'h08000,
    PH_MA_A = 20'h10000,
    PH_MA_B = 20'h20000,
    PH_MA_C = 20'h40000,
    PH_MA_D = 20'h80000
  } phase_e;

  // Operations of a transaction sequence.
  typedef enum logic [3:0] {
    OP_START  = 4'd0,
    OP_TXDEV  = 4'd1,
    OP_TXDEVR = 4'd2,
    OP_TXSUB  = 4'd3,
    OP_TXDATA = 4'd4,
    OP_ACKCHK = 4'd5,
    OP_ACK    = 4'd6,
    OP_STOP   = 4'd7,
    OP_RXLOOP = 4'd8,
    OP_END    = 4'd9
  } op_e;

  // Outcome of entering a sequence step.
  typedef struct packed {
    phase_e     phase;
    logic [3:0] step;
    logic       ld_shift;
    logic [7:0] shift;
    logic       fin;
  } enter_t;

  // One result item.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [1:0] status;
    logic [7:0] rdata;
    logic       rvalid;
    logic       rlast;
  } res_t;

  // Operation at a given step of a write or read transaction.
  function automatic op_e seq_op(logic is_wr, logic [3:0] step);
    logic [3:0] s;
    op_e        op;
    s  = (step > SeqLast) ? SeqLast : step;
    op = OP_END;
    if (is_wr) begin
      case (s)
        4'd0:    op = OP_START;
        4'd1:    op = OP_TXDEV;
        4'd2:    op = OP_ACKCHK;
        4'd3:    op = OP_TXSUB;
        4'd4:    op = OP_ACK;
        4'd5:    op = OP_TXDATA;
        4'd6:    op = OP_ACK;
        4'd7:    op = OP_STOP;
        default: op = OP_END;
      endcase
    end else begin
      case (s)
        4'd0:    op = OP_START;
        4'd1:    op = OP_TXDEV;
        4'd2:    op = OP_ACKCHK;
        4'd3:    op = OP_TXSUB;
        4'd4:    op = OP_ACK;
        4'd5:    op = OP_STOP;
        4'd6:    op = OP_START;
        4'd7:    op = OP_TXDEVR;
        4'd8:    op = OP_ACKCHK;
        4'd9:    op = OP_RXLOOP;
        4'd10:   op = OP_STOP;
        default: op = OP_END;
      endcase
    end
    return op;
  endfunction

  // Work out the phase and shift register load on entering a step. An empty
  // read loop is skipped straight to the following step.
  function automatic enter_t enter_f(logic is_wr, logic [3:0] step, logic bytes_zero,
                                     logic [7:0] dev, logic [7:0] sub, logic [7:0] wdata);
    enter_t e;
    op_e    op;
    e.phase    = PH_IDLE;
    e.step     = step;
    e.ld_shift = 1'b0;
    e.shift    = 8'd0;
    e.fin      = 1'b0;
    op = seq_op(is_wr, step);
    if (op == OP_RXLOOP && bytes_zero) begin
      e.step = step + 4'd1;
      op     = seq_op(is_wr, e.step);
    end
    case (op) inside
      OP_START: e.phase = PH_ST_A;
      OP_TXDEV, OP_TXDEVR, OP_TXSUB, OP_TXDATA: begin
        e.phase    = PH_TX_A;
        e.ld_shift = 1'b1;
        case (op)
          OP_TXDEV:  e.shift = dev;
          OP_TXDEVR: e.shift = dev + 8'd1;
          OP_TXSUB:  e.shift = sub;
          default:   e.shift = wdata;
        endcase
      end
      OP_ACKCHK, OP_ACK: e.phase = PH_AW_A;
      OP_STOP: e.phase = PH_SP_A;
      OP_RXLOOP: begin
        e.phase    = PH_RX_A;
        e.ld_shift = 1'b1;
        e.shift    = 8'd0;
      end
      default: e.fin = 1'b1;
    endcase
    return e;
  endfunction

endpackage

// ----- rtl/sccb_rm_seq.sv -----
// ----------------------------------------------------------------------------
// SCCB register master sequencer
// Bus phase state machine, phase timer, bit shifter and step sequencer; one
// tick per item, with the result formed combinationally from the state.
// ----------------------------------------------------------------------------
module sccb_rm_seq #(
  parameter int unsigned MaxReadBytes = sccb_rm_pkg::MaxReadBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_en_i,
  input  logic [1:0]         req_type_i,
  input  logic [7:0]         sub_address_i,
  input  logic [7:0]         write_data_i,
  input  logic [8:0]         read_length_i,
  input  logic               sda_in_i,
  input  logic [7:0]         dev_addr_i,
  input  logic [15:0]        delay_ticks_i,
  output sccb_rm_pkg::res_t  res_o
);

  localparam int unsigned LenW = $clog2(MaxReadBytes + 1);

  sccb_rm_pkg::phase_e phase_q, phase_d;
  logic [15:0]     delay_q, delay_d;
  logic [3:0]      bit_q, bit_d;
  logic [7:0]      shift_q, shift_d;
  logic            is_wr_q, is_wr_d;
  logic [7:0]      sub_q, sub_d;
  logic [7:0]      data_q, data_d;
  logic [LenW-1:0] bytes_q, bytes_d;
  logic [3:0]      step_q, step_d;
  logic [1:0]      stat_q, stat_d;
  logic            held_q, held_d;

  sccb_rm_pkg::enter_t ent;
  sccb_rm_pkg::res_t   res;
  logic                do_enter;
  logic                ackbit;
  logic [15:0]         dly_lim;
  logic [15:0]         dly_inc;
  logic [LenW-1:0]     len_sat;

  // Line drive, phase timing and step sequencing for one tick.
  always_comb begin
    phase_d  = phase_q;
    delay_d  = delay_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    is_wr_d  = is_wr_q;
    sub_d    = sub_q;
    data_d   = data_q;
    bytes_d  = bytes_q;
    step_d   = step_q;
    stat_d   = stat_q;
    do_enter = 1'b0;
    ent      = '0;
    res      = '0;
    ackbit   = (bytes_q == LenW'(1));
    dly_lim  = (delay_ticks_i == 16'd0) ? 16'd1 : delay_ticks_i;
    dly_inc  = delay_q + 16'd1;
    if ({23'd0, read_length_i} > 32'(MaxReadBytes)) begin
      len_sat = LenW'(MaxReadBytes);
    end else begin
      len_sat = LenW'(read_length_i);
    end

    // Line levels during this tick.
    res.scl = 1'b1;
    res.sda = 1'b1;
    unique case (phase_q)
      sccb_rm_pkg::PH_ST_B, sccb_rm_pkg::PH_ST_C: res.sda = 1'b0;
      sccb_rm_pkg::PH_TX_A, sccb_rm_pkg::PH_AW_A,
      sccb_rm_pkg::PH_SP_A, sccb_rm_pkg::PH_MA_A: begin
        res.scl = 1'b0;
        res.sda = held_q;
      end
      sccb_rm_pkg::PH_TX_B: begin
        res.scl = 1'b0;
        res.sda = shift_q[7];
      end
      sccb_rm_pkg::PH_TX_C: res.sda = shift_q[7];
      sccb_rm_pkg::PH_AW_B, sccb_rm_pkg::PH_RX_A: res.scl = 1'b0;
      sccb_rm_pkg::PH_SP_B: begin
        res.scl = 1'b0;
        res.sda = 1'b0;
      end
      sccb_rm_pkg::PH_SP_C: res.sda = 1'b0;
      sccb_rm_pkg::PH_MA_B, sccb_rm_pkg::PH_MA_D: begin
        res.scl = 1'b0;
        res.sda = ackbit;
      end
      sccb_rm_pkg::PH_MA_C: res.sda = ackbit;
      default: ;
    endcase
    held_d = res.sda;

    if (phase_q == sccb_rm_pkg::PH_IDLE) begin
      // A new request is taken only while idle.
      if (req_type_i == sccb_rm_pkg::ReqWrite || req_type_i == sccb_rm_pkg::ReqRead) begin
        is_wr_d  = (req_type_i == sccb_rm_pkg::ReqWrite);
        sub_d    = sub_address_i;
        data_d   = write_data_i;
        bytes_d  = len_sat;
        stat_d   = sccb_rm_pkg::StatOk;
        delay_d  = 16'd0;
        do_enter = 1'b1;
        ent = sccb_rm_pkg::enter_f(is_wr_d, 4'd0, len_sat == '0, dev_addr_i,
                                   sub_address_i, write_data_i);
      end
    end else begin
      delay_d = dly_inc;
      if (dly_inc >= dly_lim) begin
        // End of a bus phase; SDA is sampled here.
        delay_d = 16'd0;
        unique case (phase_q)
          sccb_rm_pkg::PH_ST_A: begin
            if (!sda_in_i) begin
              phase_d    = sccb_rm_pkg::PH_IDLE;
              res.done   = 1'b1;
              res.status = sccb_rm_pkg::StatBusBusy;
            end else begin
              phase_d = sccb_rm_pkg::PH_ST_B;
            end
          end
          sccb_rm_pkg::PH_ST_B: begin
            if (sda_in_i) begin
              phase_d    = sccb_rm_pkg::PH_IDLE;
              res.done   = 1'b1;
              res.status = sccb_rm_pkg::StatBusBusy;
            end else begin
              phase_d = sccb_rm_pkg::PH_ST_C;
            end
          end
          sccb_rm_pkg::PH_TX_A: phase_d = sccb_rm_pkg::PH_TX_B;
          sccb_rm_pkg::PH_TX_B: phase_d = sccb_rm_pkg::PH_TX_C;
          sccb_rm_pkg::PH_TX_C: begin
            shift_d = {shift_q[6:0], 1'b0};
            bit_d   = bit_q + 4'd1;
            if (bit_d >= 4'd8) begin
              do_enter = 1'b1;
              ent = sccb_rm_pkg::enter_f(is_wr_q, step_q + 4'd1, bytes_q == '0,
                                         dev_addr_i, sub_q, data_q);
            end else begin
              phase_d = sccb_rm_pkg::PH_TX_A;
            end
          end
          sccb_rm_pkg::PH_AW_A: phase_d = sccb_rm_pkg::PH_AW_B;
          sccb_rm_pkg::PH_AW_B: phase_d = sccb_rm_pkg::PH_AW_C;
          sccb_rm_pkg::PH_AW_C: begin
            do_enter = 1'b1;
            if (sccb_rm_pkg::seq_op(is_wr_q, step_q) == sccb_rm_pkg::OP_ACKCHK && sda_in_i)
            begin
              // Device address not acknowledged: send the stop and finish.
              stat_d = sccb_rm_pkg::StatNoAck;
              ent = sccb_rm_pkg::enter_f(is_wr_q,
                                         is_wr_q ? sccb_rm_pkg::SeqWrStop
                                                 : sccb_rm_pkg::SeqRdStop,
                                         bytes_q == '0, dev_addr_i, sub_q, data_q);
            end else begin
              ent = sccb_rm_pkg::enter_f(is_wr_q, step_q + 4'd1, bytes_q == '0,
                                         dev_addr_i, sub_q, data_q);
            end
          end
          sccb_rm_pkg::PH_SP_A: phase_d = sccb_rm_pkg::PH_SP_B;
          sccb_rm_pkg::PH_SP_B: phase_d = sccb_rm_pkg::PH_SP_C;
          sccb_rm_pkg::PH_SP_C: phase_d = sccb_rm_pkg::PH_SP_D;
          sccb_rm_pkg::PH_ST_C, sccb_rm_pkg::PH_SP_D: begin
            do_enter = 1'b1;
            ent = sccb_rm_pkg::enter_f(is_wr_q, step_q + 4'd1, bytes_q == '0,
                                       dev_addr_i, sub_q, data_q);
          end
          sccb_rm_pkg::PH_RX_A: phase_d = sccb_rm_pkg::PH_RX_B;
          sccb_rm_pkg::PH_RX_B: begin
            shift_d = {shift_q[6:0], sda_in_i};
            bit_d   = bit_q + 4'd1;
            if (bit_d >= 4'd8) begin
              res.rvalid = 1'b1;
              res.rdata  = shift_d;
              res.rlast  = ackbit;
              phase_d    = sccb_rm_pkg::PH_MA_A;
            end else begin
              phase_d = sccb_rm_pkg::PH_RX_A;
            end
          end
          sccb_rm_pkg::PH_MA_A: phase_d = sccb_rm_pkg::PH_MA_B;
          sccb_rm_pkg::PH_MA_B: phase_d = sccb_rm_pkg::PH_MA_C;
          sccb_rm_pkg::PH_MA_C: phase_d = sccb_rm_pkg::PH_MA_D;
          sccb_rm_pkg::PH_MA_D: begin
            if (bytes_q != '0) begin
              bytes_d = bytes_q - LenW'(1);
            end
            do_enter = 1'b1;
            ent = sccb_rm_pkg::enter_f(is_wr_q, step_q, bytes_d == '0,
                                       dev_addr_i, sub_q, data_q);
          end
          default: phase_d = sccb_rm_pkg::PH_IDLE;
        endcase
      end
    end

    // Apply the outcome of entering a new step.
    if (do_enter) begin
      phase_d = ent.phase;
      step_d  = ent.step;
      if (ent.ld_shift) begin
        shift_d = ent.shift;
        bit_d   = 4'd0;
      end
      if (ent.fin) begin
        res.done   = 1'b1;
        res.status = stat_d;
      end
    end
    if (phase_d == sccb_rm_pkg::PH_IDLE && phase_q == sccb_rm_pkg::PH_IDLE && !do_enter) begin
      step_d = step_q;
    end
    res.busy = (phase_d != sccb_rm_pkg::PH_IDLE);
  end

  // State registers advance once per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sccb_rm_pkg::PH_IDLE;
      delay_q <= 16'd0;
      bit_q   <= 4'd0;
      shift_q <= 8'd0;
      is_wr_q <= 1'b0;
      sub_q   <= 8'd0;
      data_q  <= 8'd0;
      bytes_q <= '0;
      step_q  <= 4'd0;
      stat_q  <= sccb_rm_pkg::StatOk;
      held_q  <= 1'b1;
    end else if (step_en_i) begin
      phase_q <= phase_d;
      delay_q <= delay_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      is_wr_q <= is_wr_d;
      sub_q   <= sub_d;
      data_q  <= data_d;
      bytes_q <= bytes_d;
      step_q  <= step_d;
      stat_q  <= stat_d;
      held_q  <= held_d;
    end
  end

  assign res_o = res;

  // A finished transaction leaves the block idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res.done |-> !res.busy)
    else $error("done reported while still busy");

  // The last flag only comes with a received byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res.rlast |-> res.rvalid)
    else $error("read_last without read_valid");

  // A non-zero status is reported only with done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (res.status != sccb_rm_pkg::StatOk) |-> res.done)
    else $error("status reported without done");

  // A received byte ends the eighth bit of a receive phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   res.rvalid |-> (phase_q == sccb_rm_pkg::PH_RX_B && bit_q == 4'd7))
    else $error("byte reported outside the last receive bit");

  // The phase register stays one-hot.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(phase_q))
    else $error("phase register not one-hot");

endmodule

// ----- rtl/sccb_register_master_top.sv -----
// ----------------------------------------------------------------------------
// SCCB register master, top level
// Stream wrapper with input register, result register and configuration port.
// ----------------------------------------------------------------------------
// Each input item is one tick of the SCCB bus sequencer and yields one result
// item carrying the SCL and SDA drive for that tick. One item is taken every
// clock cycle while the result register is free or its item is taken; items pass
// the input register, the sequencer and the result register. The bus itself moves
// one phase every delay_ticks items: a sent bit takes three phases, a received bit two,
// an acknowledge sent by the master four. The user must write configuration only while
// no transaction is running; the block does not enforce it. cfg_ready_o is always high.
module sccb_register_master_top #(
  parameter int unsigned MaxReadBytes = sccb_rm_pkg::MaxReadBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // sub_address[7:0], write_data[15:8],
                                     // read_length[24:16], sda_in[25], zero[31:26]
  input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // scl_out[0], sda_out[1], busy_res[2], done_res[3],
                                     // status[5:4], read_data[13:6], zero[15:14]
  output logic        m_axis_tuser,  // read_valid[0]
  output logic        m_axis_tlast,  // read_last
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_addr_i,
  input  logic [15:0] cfg_data_i
);

  logic              in_valid_q;
  logic [1:0]        req_q;
  logic [25:0]       in_data_q;
  logic              out_valid_q;
  logic [15:0]       out_data_q;
  logic              out_user_q;
  logic              out_last_q;
  logic              adv;
  logic [7:0]        dev_addr_q;
  logic [15:0]       delay_ticks_q;
  sccb_rm_pkg::res_t res;

  // The result register frees when empty or when its item is taken.
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || adv;
  assign cfg_ready_o   = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= sccb_rm_pkg::DevAddrReset;
      delay_ticks_q <= sccb_rm_pkg::DelayTicksReset;
    end else if (cfg_valid_i) begin
      if (cfg_addr_i == sccb_rm_pkg::CfgDevAddr) begin
        dev_addr_q <= cfg_data_i[7:0];
      end else begin
        delay_ticks_q <= cfg_data_i;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      req_q     <= s_axis_tuser;
      in_data_q <= s_axis_tdata[25:0];
    end
  end

  sccb_rm_seq #(
    .MaxReadBytes (MaxReadBytes)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_en_i     (in_valid_q && adv),
    .req_type_i    (req_q),
    .sub_address_i (in_data_q[7:0]),
    .write_data_i  (in_data_q[15:8]),
    .read_length_i (in_data_q[24:16]),
    .sda_in_i      (in_data_q[25]),
    .dev_addr_i    (dev_addr_q),
    .delay_ticks_i (delay_ticks_q),
    .res_o         (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_q) begin
      out_data_q <= {2'b00, res.rdata, res.status, res.done, res.busy, res.sda, res.scl};
      out_user_q <= res.rvalid;
      out_last_q <= res.rlast;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ----- sim/tb_sccb_register_master_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the SCCB register master top level
// Every input item is one bus tick. A planner builds whole write and read
// transactions and gives SDA the levels that a slave would drive, faulty now
// and then. An internal model of the sequencer predicts the drive of every
// tick, and each result item is checked field by field against it.
// ----------------------------------------------------------------------------
module tb_sccb_register_master_top;
  import sccb_rm_pkg::*;

  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomTicks = 1150;
  localparam int unsigned MaxReported = 100;
  localparam logic [1:0]  ReqUnused   = 2'd3;
  // Steps of a transaction that check the device address acknowledge.
  localparam logic [3:0]  DevAckStep   = 4'd2;
  localparam logic [3:0]  RdDevAckStep = 4'd8;

  // Ways in which the attached slave departs from a well-behaved one.
  typedef enum int {
    BusClean, BusHeldLow, BusHeldHigh, BusNackDev, BusNackRdDev
  } bus_fault_e;

  // One input item: one tick of the sequencer.
  typedef struct packed {
    logic [1:0] req;
    logic [7:0] sub;
    logic [7:0] wdata;
    logic [8:0] len;
    logic       sda;
  } tick_t;

  // Sequencer state as the model keeps it.
  typedef struct packed {
    phase_e      ph;
    logic [15:0] dcnt;
    logic [3:0]  bits;
    logic [7:0]  shreg;
    logic [1:0]  kind;
    logic [7:0]  sub;
    logic [7:0]  wdata;
    logic [8:0]  left;
    logic [3:0]  step;
    logic [1:0]  stat;
    logic        sda_held;
  } sccb_state_t;

  localparam sccb_state_t IdleState = '{ph: PH_IDLE, sda_held: 1'b1, default: '0};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = ReqNone;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_addr_i = CfgDevAddr;
  logic [15:0] cfg_data_i = '0;

  // Register copies, the two model states and the item stores.
  logic [7:0]  dev_addr = DevAddrReset;
  logic [15:0] ticks_per_phase = DelayTicksReset;
  sccb_state_t line_st;
  sccb_state_t plan_st;
  bus_fault_e  bus_fault = BusClean;
  tick_t       tick_q[$];
  res_t        tick_res_q[$];
  tick_t       cur_tick = '0;

  int unsigned ticks_planned = 0;
  int unsigned results_seen = 0;
  int unsigned work_ticks = 0;
  int unsigned fails = 0;
  int unsigned cycles = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned stall_cnt = 0;
  int unsigned stall_mode = 0;
  int unsigned txn_count = 0;
  int unsigned txn_ok = 0;
  int unsigned txn_busy = 0;
  int unsigned txn_nack = 0;
  int unsigned bytes_read = 0;
  int unsigned cfg_writes = 0;

  sccb_register_master_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Operation at a step of a write or a read; past the end everything is the end.
  function automatic op_e txn_op(input logic [1:0] kind, input logic [3:0] step);
    op_e op;
    op = OP_END;
    case (step)
      4'd0: op = OP_START;
      4'd1: op = OP_TXDEV;
      4'd2: op = OP_ACKCHK;
      4'd3: op = OP_TXSUB;
      4'd4: op = OP_ACK;
      default: begin
        if (kind == ReqWrite) begin
          if (step == 4'd5) op = OP_TXDATA;
          else if (step == 4'd6) op = OP_ACK;
          else if (step == 4'd7) op = OP_STOP;
        end else begin
          case (step)
            4'd5, 4'd10: op = OP_STOP;
            4'd6:        op = OP_START;
            4'd7:        op = OP_TXDEVR;
            4'd8:        op = OP_ACKCHK;
            4'd9:        op = OP_RXLOOP;
            default:     op = OP_END;
          endcase
        end
      end
    endcase
    return op;
  endfunction

  // Set up the first phase of the current step; a read with nothing left to
  // receive goes straight on to its stop.
  function automatic void enter_step(inout sccb_state_t s, input logic [7:0] dev,
                                     inout res_t r);
    op_e op;
    op = txn_op(s.kind, s.step);
    if (op == OP_RXLOOP && s.left == 9'd0) begin
      s.step = s.step + 4'd1;
      op = txn_op(s.kind, s.step);
    end
    case (op)
      OP_START: s.ph = PH_ST_A;
      OP_TXDEV, OP_TXDEVR, OP_TXSUB, OP_TXDATA: begin
        s.shreg = (op == OP_TXDEV)  ? dev :
                  (op == OP_TXDEVR) ? dev + 8'd1 :
                  (op == OP_TXSUB)  ? s.sub : s.wdata;
        s.bits = '0;
        s.ph = PH_TX_A;
      end
      OP_ACKCHK, OP_ACK: s.ph = PH_AW_A;
      OP_STOP: s.ph = PH_SP_A;
      OP_RXLOOP: begin
        s.shreg = '0;
        s.bits = '0;
        s.ph = PH_RX_A;
      end
      default: begin
        s.ph = PH_IDLE;
        r.done = 1'b1;
        r.status = s.stat;
      end
    endcase
  endfunction

  // Move on once a phase has run its full length; SDA is sampled here.
  function automatic void end_phase(inout sccb_state_t s, input logic [7:0] dev,
                                    input logic sda, inout res_t r);
    case (s.ph)
      PH_ST_A, PH_ST_B: begin
        // A line held low before the start, or still high after it, is a busy bus.
        if ((s.ph == PH_ST_A) != sda) begin
          s.ph = PH_IDLE;
          r.done = 1'b1;
          r.status = StatBusBusy;
        end else begin
          s.ph = (s.ph == PH_ST_A) ? PH_ST_B : PH_ST_C;
        end
      end
      PH_ST_C, PH_SP_D: begin
        s.step = s.step + 4'd1;
        enter_step(s, dev, r);
      end
      PH_TX_A: s.ph = PH_TX_B;
      PH_TX_B: s.ph = PH_TX_C;
      PH_TX_C: begin
        s.shreg = s.shreg << 1;
        s.bits = s.bits + 4'd1;
        if (s.bits >= 4'd8) begin
          s.step = s.step + 4'd1;
          enter_step(s, dev, r);
        end else begin
          s.ph = PH_TX_A;
        end
      end
      PH_AW_A: s.ph = PH_AW_B;
      PH_AW_B: s.ph = PH_AW_C;
      PH_AW_C: begin
        // Only the device address acknowledge matters; a miss sends the stop.
        if (txn_op(s.kind, s.step) == OP_ACKCHK && sda) begin
          s.stat = StatNoAck;
          s.step = (s.kind == ReqWrite) ? SeqWrStop : SeqRdStop;
        end else begin
          s.step = s.step + 4'd1;
        end
        enter_step(s, dev, r);
      end
      PH_SP_A: s.ph = PH_SP_B;
      PH_SP_B: s.ph = PH_SP_C;
      PH_SP_C: s.ph = PH_SP_D;
      PH_RX_A: s.ph = PH_RX_B;
      PH_RX_B: begin
        s.shreg = {s.shreg[6:0], sda};
        s.bits = s.bits + 4'd1;
        if (s.bits >= 4'd8) begin
          r.rvalid = 1'b1;
          r.rdata = s.shreg;
          r.rlast = (s.left == 9'd1);
          s.ph = PH_MA_A;
        end else begin
          s.ph = PH_RX_A;
        end
      end
      PH_MA_A: s.ph = PH_MA_B;
      PH_MA_B: s.ph = PH_MA_C;
      PH_MA_C: s.ph = PH_MA_D;
      PH_MA_D: begin
        if (s.left != 9'd0) s.left = s.left - 9'd1;
        enter_step(s, dev, r);
      end
      default: s.ph = PH_IDLE;
    endcase
  endfunction

  // Bus drive and report of one tick, advancing the given state.
  function automatic res_t bus_tick(inout sccb_state_t s, input logic [7:0] dev,
                                    input logic [15:0] dly, input tick_t t);
    res_t        r;
    logic        ack_lvl;
    logic [15:0] d;
    r = '0;
    r.scl = 1'b1;
    r.sda = 1'b1;
    ack_lvl = (s.left == 9'd1);
    d = (dly == 16'd0) ? 16'd1 : dly;
    case (s.ph)
      PH_ST_B, PH_ST_C: r.sda = 1'b0;
      PH_TX_A, PH_AW_A, PH_SP_A, PH_MA_A: begin
        r.scl = 1'b0;
        r.sda = s.sda_held;
      end
      PH_TX_B: begin
        r.scl = 1'b0;
        r.sda = s.shreg[7];
      end
      PH_TX_C: r.sda = s.shreg[7];
      PH_AW_B, PH_RX_A: r.scl = 1'b0;
      PH_SP_B: begin
        r.scl = 1'b0;
        r.sda = 1'b0;
      end
      PH_SP_C: r.sda = 1'b0;
      PH_MA_B, PH_MA_D: begin
        r.scl = 1'b0;
        r.sda = ack_lvl;
      end
      PH_MA_C: r.sda = ack_lvl;
      default: ;
    endcase
    s.sda_held = r.sda;
    if (s.ph == PH_IDLE) begin
      if (t.req == ReqWrite || t.req == ReqRead) begin
        s.kind = t.req;
        s.sub = t.sub;
        s.wdata = t.wdata;
        s.left = (t.len > MaxReadBytesDef) ? 9'(MaxReadBytesDef) : t.len;
        s.step = '0;
        s.stat = StatOk;
        s.dcnt = '0;
        enter_step(s, dev, r);
      end
    end else begin
      s.dcnt = s.dcnt + 16'd1;
      if (s.dcnt >= d) begin
        s.dcnt = '0;
        end_phase(s, dev, t.sda, r);
      end
    end
    r.busy = (s.ph != PH_IDLE);
    return r;
  endfunction

  // Plan one tick. On the tick that ends a start phase or a device address acknowledge,
  // SDA carries what the slave would drive; on every other tick it is random.
  task automatic plan_tick(input logic [1:0] req, input logic [7:0] sub,
                           input logic [7:0] wdata, input logic [8:0] len);
    tick_t       t;
    logic [15:0] d;
    d = (ticks_per_phase == 16'd0) ? 16'd1 : ticks_per_phase;
    t.req = req;
    t.sub = sub;
    t.wdata = wdata;
    t.len = len;
    t.sda = 1'($urandom_range(0, 1));
    if (plan_st.ph != PH_IDLE && {1'b0, plan_st.dcnt} + 17'd1 >= {1'b0, d}) begin
      case (plan_st.ph)
        PH_ST_A: t.sda = (bus_fault != BusHeldLow);
        PH_ST_B: t.sda = (bus_fault == BusHeldHigh);
        PH_AW_C: begin
          if (txn_op(plan_st.kind, plan_st.step) == OP_ACKCHK)
            t.sda = (bus_fault == BusNackDev && plan_st.step == DevAckStep) ||
                    (bus_fault == BusNackRdDev && plan_st.step == RdDevAckStep);
        end
        default: ;
      endcase
    end
    if (plan_st.ph != PH_IDLE || req == ReqWrite || req == ReqRead) work_ticks++;
    void'(bus_tick(plan_st, dev_addr, ticks_per_phase, t));
    tick_q.push_back(t);
    ticks_planned++;
  endtask

  // Plan a whole transaction: the request, random requests while it runs
  // (ignored by the block), then a few idle ticks.
  task automatic plan_txn(input logic [1:0] kind, input logic [7:0] sub,
                          input logic [7:0] wdata, input logic [8:0] len,
                          input bus_fault_e fault);
    bus_fault = fault;
    plan_tick(kind, sub, wdata, len);
    while (plan_st.ph != PH_IDLE)
      plan_tick(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 9'($urandom));
    repeat ($urandom_range(0, 3))
      plan_tick($urandom_range(0, 1) ? ReqNone : ReqUnused, 8'($urandom), 8'($urandom),
                9'($urandom));
  endtask

  // Wait until every planned item has come back, then let the pipeline settle.
  task automatic drain();
    while (results_seen < ticks_planned) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Register write, only once the block has gone quiet.
  task automatic set_reg(input logic idx, input logic [15:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgDevAddr) dev_addr = val[7:0];
    else ticks_per_phase = val;
    cfg_writes++;
  endtask

  task automatic compare_field(input string fname, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      fails++;
      if (fails <= MaxReported)
        $error("%s: expected %0h, got %0h (result item %0d)", fname, want, got, results_seen);
    end
  endtask

  // Sender: bursts of random length with random gaps between them. The model
  // advances on each accepted item.
  always @(posedge clk_i) begin
    logic take;
    logic nxt_valid;
    take = rst_ni && s_axis_tvalid && s_axis_tready;
    if (take) tick_res_q.push_back(bus_tick(line_st, dev_addr, ticks_per_phase, cur_tick));
    nxt_valid = s_axis_tvalid && !take;
    if (rst_ni && !nxt_valid) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (tick_q.size() != 0) begin
        cur_tick = tick_q.pop_front();
        nxt_valid = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                                   : $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    s_axis_tvalid <= nxt_valid;
    s_axis_tdata <= {6'd0, cur_tick.sda, cur_tick.len, cur_tick.wdata, cur_tick.sub};
    s_axis_tuser <= cur_tick.req;
  end

  // Receiver: check each result item, and stall on one of four patterns,
  // chosen anew at random.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (tick_res_q.size() == 0) begin
          fails++;
          $error("result item %0d arrived with none expected", results_seen);
        end else begin
          want = tick_res_q.pop_front();
          compare_field("scl_out", want.scl, m_axis_tdata[0]);
          compare_field("sda_out", want.sda, m_axis_tdata[1]);
          compare_field("busy_res", want.busy, m_axis_tdata[2]);
          compare_field("done_res", want.done, m_axis_tdata[3]);
          compare_field("status", want.status, m_axis_tdata[5:4]);
          compare_field("read_data", want.rdata, m_axis_tdata[13:6]);
          compare_field("read_valid", want.rvalid, m_axis_tuser);
          compare_field("read_last", want.rlast, m_axis_tlast);
          if (want.done) begin
            txn_count++;
            if (want.status == StatOk) txn_ok++;
            else if (want.status == StatBusBusy) txn_busy++;
            else txn_nack++;
          end
          if (want.rvalid) bytes_read++;
        end
      end
      stall_cnt++;
      if (stall_cnt % 200 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= (stall_cnt % 8 != 0);
        default: m_axis_tready <= ((stall_cnt / 8) % 2 == 0);
      endcase
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d of %0d result items seen.",
               cycles, results_seen, ticks_planned);
      $display("sccb_register_master_top test failed");
      $finish;
    end
  end

  initial begin
    int unsigned rand_goal;
    int unsigned pick;
    line_st = IdleState;
    plan_st = IdleState;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: the line is held low before the start.
    plan_txn(ReqWrite, 8'h5A, 8'hC3, 9'd0, BusHeldLow);

    // Shortest phase: both operations, both start faults and both address checks.
    set_reg(CfgDelayTicks, 16'd1);
    plan_txn(ReqWrite, 8'h00, 8'h00, 9'd0, BusClean);
    plan_txn(ReqWrite, 8'hFF, 8'hFF, 9'h1FF, BusClean);
    plan_txn(ReqWrite, 8'h3C, 8'h81, 9'd0, BusNackDev);
    plan_txn(ReqWrite, 8'h96, 8'h69, 9'd5, BusHeldHigh);
    plan_txn(ReqRead, 8'h10, 8'h00, 9'd0, BusClean);
    plan_txn(ReqRead, 8'hA5, 8'h00, 9'd1, BusClean);
    plan_txn(ReqRead, 8'h01, 8'hFF, 9'd3, BusClean);
    plan_txn(ReqRead, 8'h7E, 8'h00, 9'd2, BusNackDev);
    plan_txn(ReqRead, 8'h80, 8'h00, 9'd2, BusNackRdDev);
    plan_txn(ReqRead, 8'h44, 8'h00, 9'd2, BusHeldLow);
    // A length beyond the maximum is cut down to it.
    plan_txn(ReqRead, 8'hC0, 8'h00, 9'd300, BusClean);

    // Device address extremes; at the top the read address wraps round to zero.
    set_reg(CfgDevAddr, 16'hFF00);
    plan_txn(ReqRead, 8'h22, 8'h00, 9'd2, BusClean);
    set_reg(CfgDevAddr, 16'h00FF);
    plan_txn(ReqRead, 8'h33, 8'h00, 9'd1, BusClean);
    set_reg(CfgDevAddr, 16'd254);
    plan_txn(ReqWrite, 8'h55, 8'hAA, 9'd0, BusClean);

    // A zero phase length behaves as one; the longest one ends in a busy bus.
    set_reg(CfgDelayTicks, 16'd0);
    plan_txn(ReqWrite, 8'h0F, 8'hF0, 9'd0, BusClean);
    plan_txn(ReqRead, 8'hF0, 8'h00, 9'd1, BusClean);
    set_reg(CfgDelayTicks, 16'hFFFF);
    plan_txn(ReqWrite, 8'h12, 8'h34, 9'd0, BusHeldLow);
    set_reg(CfgDelayTicks, 16'd1);

    // Random transactions, mostly well formed, with the registers changed now and then.
    rand_goal = work_ticks + RandomTicks;
    while (work_ticks < rand_goal) begin
      if ($urandom_range(0, 3) == 0) begin
        set_reg(CfgDevAddr, 16'($urandom));
        pick = $urandom_range(0, 9);
        set_reg(CfgDelayTicks, (pick < 6) ? 16'd1 : (pick < 8) ? 16'd2 : 16'd3);
      end
      pick = $urandom_range(0, 9);
      plan_txn($urandom_range(0, 1) ? ReqWrite : ReqRead, 8'($urandom), 8'($urandom),
               ($urandom_range(0, 3) != 0) ? 9'($urandom_range(0, 3))
                                           : 9'($urandom_range(4, 12)),
               (pick == 0) ? BusHeldLow : (pick == 1) ? BusHeldHigh :
               (pick == 2) ? BusNackDev : (pick == 3) ? BusNackRdDev : BusClean);
    end

    drain();
    if (tick_res_q.size() != 0) begin
      fails++;
      $error("%0d expected result items never arrived", tick_res_q.size());
    end
    $display("Checked %0d bus ticks over %0d transactions: %0d completed, %0d bus busy, %0d unacknowledged.",
             results_seen, txn_count, txn_ok, txn_busy, txn_nack);
    $display("Received %0d read bytes; %0d register writes.", bytes_read, cfg_writes);
    if (fails == 0) begin
      $display("sccb_register_master_top test passed");
    end else begin
      $display("sccb_register_master_top test failed");
    end
    $finish;
  end

endmodule
